>>> rtl/core/binding_store_with_undo_trail_assert.svh
// assertion macros shared by the binding store rtl
`ifndef BINDING_STORE_WITH_UNDO_TRAIL_ASSERT_SVH
`define BINDING_STORE_WITH_UNDO_TRAIL_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define BST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("binding store check failed");

// next-cycle implication, ignored while reset is high
`define BST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("binding store check failed");

`endif

>>> rtl/core/bst_pkg.sv
// shared types and codes of the binding store
package bst_pkg;

   localparam int OPCODE_W = 2;
   localparam int VAR_ID_W = 16;
   localparam int VALUE_W  = 32;
   localparam int MARK_W   = 7;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 7;

   localparam logic [OPCODE_W-1:0] OP_BIND  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_MARK  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_VAR   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BOUND   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

   // probe token handed from cell to cell
   typedef struct packed {
      logic live;
      logic found;
   } bst_tok_type;

endpackage

>>> rtl/core/bst_cell.sv
// one binding slot of the row, with its stage of the search probe
module bst_cell #(
   parameter int VARIABLE_BITS = 16,
   parameter int VALUE_BITS    = 32,
   parameter int COUNT_BITS    = 7,
   parameter int IDX_BITS      = 6,
   parameter int CELL_INDEX    = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bst_pkg::bst_tok_type     tok_in,
   input  logic [IDX_BITS-1:0]      pos_in,
   output bst_pkg::bst_tok_type     tok_out,
   output logic [IDX_BITS-1:0]      pos_out,
   input  logic [VARIABLE_BITS-1:0] key,
   input  logic [COUNT_BITS-1:0]    count,
   input  logic                     wr_en,
   input  logic [VARIABLE_BITS-1:0] wr_var,
   input  logic [VALUE_BITS-1:0]    wr_val
);

   localparam logic [COUNT_BITS-1:0] MY_SLOT = COUNT_BITS'(CELL_INDEX);
   localparam logic [IDX_BITS-1:0]   MY_POS  = IDX_BITS'(CELL_INDEX);

   logic [VARIABLE_BITS-1:0] var_ff;
   logic [VALUE_BITS-1:0]    val_ff;
   bst_pkg::bst_tok_type     tok_ff, tok_pass_in;
   logic [IDX_BITS-1:0]      pos_ff, pos_pass_in;
   logic                     match;

   // slot is occupied when it sits below the fill count
   assign match = tok_in.live && !tok_in.found && (MY_SLOT < count) && (var_ff == key);

   always_comb begin
      tok_pass_in.live  = tok_in.live;
      tok_pass_in.found = tok_in.found || match;
      pos_pass_in       = match ? MY_POS : pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_pass_in;
      end
      pos_ff <= pos_pass_in;
      if (wr_en && (count == MY_SLOT)) begin
         var_ff <= wr_var;
         val_ff <= wr_val;
      end
   end

   assign tok_out = tok_ff;
   assign pos_out = pos_ff;

endmodule

>>> rtl/core/binding_store_with_undo_trail.sv
// binding store with undo trail: control, fill count and the row of binding cells
// clear and undo-to-mark go from idle to the done state, then raise rsp_valid once the result register is free
// bind and undo-through-variable first launch a probe that walks the row, then go to the done state
// a new request beat is taken only in idle, after the last one has committed its result; it may be
//   taken while that result still waits for rsp_ready
// reset: fill count zero and control idle; the stored bindings in the cells are not cleared, no sweep
`include "binding_store_with_undo_trail_assert.svh"

module binding_store_with_undo_trail #(
   parameter int STORE_DEPTH   = 64,
   parameter int VARIABLE_BITS = 16,
   parameter int VALUE_BITS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bst_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [bst_pkg::VAR_ID_W-1:0]  req_variable_id,
   input  logic [bst_pkg::VALUE_W-1:0]   req_bound_value,
   input  logic [bst_pkg::MARK_W-1:0]    req_mark_depth,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bst_pkg::DEPTH_W-1:0]   rsp_depth
);

   localparam int COUNT_BITS = $clog2(STORE_DEPTH + 1);
   localparam int IDX_BITS   = $clog2(STORE_DEPTH);
   localparam int CMP_BITS   = (COUNT_BITS > bst_pkg::MARK_W) ? COUNT_BITS : bst_pkg::MARK_W;
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(STORE_DEPTH);

   // controller states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic                           launch_ff, launch_in;
   logic [COUNT_BITS-1:0]          count_ff, count_in;

   // latched request beat
   logic [bst_pkg::OPCODE_W-1:0]   op_ff;
   logic [VARIABLE_BITS-1:0]       key_ff;
   logic [VALUE_BITS-1:0]          val_ff;
   logic [bst_pkg::MARK_W-1:0]     mark_ff;

   // search outcome taken from the tail of the row
   logic                           found_ff;
   logic [IDX_BITS-1:0]            pos_ff;

   // result register
   logic                           rsp_valid_ff;
   logic [bst_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [bst_pkg::DEPTH_W-1:0]    rsp_depth_ff;

   logic                           accept;
   logic                           slot_free;
   logic                           commit;
   logic                           write_res;
   logic [bst_pkg::STATUS_W-1:0]   status_res;
   logic [COUNT_BITS-1:0]          count_res;
   logic                           wr_en;

   bst_pkg::bst_tok_type           tok_chain [0:STORE_DEPTH];
   logic [IDX_BITS-1:0]            pos_chain [0:STORE_DEPTH];

   // no request beat is taken while reset is high
   assign req_ready = !reset && (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // result register can take a new beat this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == S_DONE) && slot_free;

   // next state and probe launch
   always_comb begin
      state_in  = state_ff;
      launch_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if ((req_opcode == bst_pkg::OP_BIND) || (req_opcode == bst_pkg::OP_VAR)) begin
                  launch_in = 1'b1;
                  state_in  = S_SCAN;
               end else begin
                  state_in  = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // probe has left the last cell
            if (tok_chain[STORE_DEPTH].live) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outcome of the operation, applied on commit
   always_comb begin
      status_res = bst_pkg::ST_OK;
      count_res  = count_ff;
      write_res  = 1'b0;
      unique case (op_ff)
         bst_pkg::OP_BIND: begin
            // already-bound check wins over the full check
            priority if (found_ff) begin
               status_res = bst_pkg::ST_BOUND;
            end else if (count_ff == FULL_COUNT) begin
               status_res = bst_pkg::ST_FULL;
            end else begin
               write_res = 1'b1;
               count_res = count_ff + COUNT_BITS'(1);
            end
         end
         bst_pkg::OP_MARK: begin
            // mark above the depth leaves the store alone
            if (CMP_BITS'(mark_ff) > CMP_BITS'(count_ff)) begin
               status_res = bst_pkg::ST_INVALID;
            end else begin
               count_res = COUNT_BITS'(mark_ff);
            end
         end
         bst_pkg::OP_VAR: begin
            // pop through the binding: depth becomes its slot index
            if (!found_ff) begin
               status_res = bst_pkg::ST_INVALID;
            end else begin
               count_res = COUNT_BITS'(pos_ff);
            end
         end
         bst_pkg::OP_CLEAR: begin
            count_res = '0;
         end
         default: begin
            count_res = count_ff;
         end
      endcase
   end

   assign count_in = commit ? count_res : count_ff;
   // bind writes the slot at the current depth
   assign wr_en    = commit && write_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         count_ff  <= count_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         op_ff    <= req_opcode;
         key_ff   <= VARIABLE_BITS'(req_variable_id);
         val_ff   <= VALUE_BITS'(req_bound_value);
         mark_ff  <= req_mark_depth;
         found_ff <= 1'b0;
      end else if ((state_ff == S_SCAN) && tok_chain[STORE_DEPTH].live) begin
         found_ff <= tok_chain[STORE_DEPTH].found;
         pos_ff   <= pos_chain[STORE_DEPTH];
      end
      if (commit) begin
         rsp_status_ff <= status_res;
         rsp_depth_ff  <= bst_pkg::DEPTH_W'(count_res);
      end
   end

   // probe enters the head of the row with nothing found yet
   always_comb begin
      tok_chain[0].live  = launch_ff;
      tok_chain[0].found = 1'b0;
      pos_chain[0]       = '0;
   end

   // row of binding cells, probe moves one cell per cycle
   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      bst_cell #(
         .VARIABLE_BITS (VARIABLE_BITS),
         .VALUE_BITS    (VALUE_BITS),
         .COUNT_BITS    (COUNT_BITS),
         .IDX_BITS      (IDX_BITS),
         .CELL_INDEX    (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok_chain[i]),
         .pos_in  (pos_chain[i]),
         .tok_out (tok_chain[i+1]),
         .pos_out (pos_chain[i+1]),
         .key     (key_ff),
         .count   (count_ff),
         .wr_en   (wr_en),
         .wr_var  (key_ff),
         .wr_val  (val_ff)
      );
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_depth  = rsp_depth_ff;

   // fill count never passes the capacity
   `BST_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   // a taken request always leaves idle
   `BST_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != S_IDLE)
   // the probe only reaches the tail during a search
   `BST_ASSERT_IMPL(a_tail_in_scan, clock, reset, tok_chain[STORE_DEPTH].live,
                    state_ff == S_SCAN)
   // a pending full result matches the held count
   `BST_ASSERT_IMPL(a_full_depth, clock, reset,
                    rsp_valid_ff && (rsp_status_ff == bst_pkg::ST_FULL),
                    count_ff == FULL_COUNT)

endmodule
